@@ design/ttlb_pkg.sv @@
// Shared types and constants for the text terminal line buffer.
// Depends on nothing; imported by ttlb_cmd and the top level of the block.
package ttlb_pkg;

   // Ring geometry
   localparam int LINE_CAPACITY = 512;
   localparam int LINE_WIDTH    = 128;
   localparam int SLOT_W        = $clog2(LINE_CAPACITY);
   localparam int COL_W         = $clog2(LINE_WIDTH);
   localparam int LEN_W         = $clog2(LINE_WIDTH + 1);
   localparam int TOTAL_W       = $clog2(LINE_CAPACITY + 1);
   localparam int CHAR_DEPTH    = LINE_CAPACITY * LINE_WIDTH;
   localparam int CHAR_AW       = $clog2(CHAR_DEPTH);

   // Configuration register indexes
   localparam logic [2:0] CSR_CODE_HARDWARE = 3'd0;
   localparam logic [2:0] CSR_CODE_CHARS    = 3'd1;
   localparam logic [2:0] CSR_CODE_TERM     = 3'd2;
   localparam logic [2:0] CSR_CODE_COMMAND  = 3'd3;
   localparam logic [2:0] CSR_TERM_COLUMNS  = 3'd4;
   localparam logic [2:0] CSR_TERM_ROWS     = 3'd5;

   // Request types
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_FETCH = 2'd2;

   // Character codes
   localparam logic [15:0] CH_NUL   = 16'h0000;
   localparam logic [15:0] CH_BS    = 16'h0008;
   localparam logic [15:0] CH_LF    = 16'h000A;
   localparam logic [15:0] CH_FF    = 16'h000C;
   localparam logic [15:0] CH_CR    = 16'h000D;
   localparam logic [15:0] CH_SPACE = 16'h0020;
   localparam logic [15:0] CH_DEL   = 16'h007F;
   localparam logic [15:0] CH_CCH   = 16'h0094;
   localparam logic [15:0] CH_NBSP  = 16'h00A0;

   typedef enum logic [2:0] {
      WM_IDLE    = 3'b001,
      WM_CHARS   = 3'b010,
      WM_COMMAND = 3'b100
   } write_mode_type;

   typedef enum logic [2:0] {
      RM_NONE = 3'b001,
      RM_HARD = 3'b010,
      RM_TERM = 3'b100
   } read_mode_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] write_value;
      logic [8:0]  fetch_line;
      logic [6:0]  fetch_column;
   } req_item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] fetch_char;
      logic        fetch_valid;
      logic [9:0]  lines_held;
      logic [7:0]  newest_length;
   } rsp_item_type;

   // Command decoder to line ring
   typedef struct packed {
      logic        edit_en;
      logic [15:0] read_data;
   } cmd_out_type;

endpackage

@@ design/text_terminal_line_buffer_unit.sv @@
// Top level of the text terminal line buffer: line ring and scanout fetch.
// Depends on ttlb_pkg, ttlb_ram and ttlb_cmd.
// The result of an item is strobed on rsp_valid in the cycle after it is accepted.
// Throughput: one item per cycle; a printable character writes the character RAM,
// a line feed writes the line-length RAM, every fetch reads both, on the accept edge.
// Reset: synchronous, active high; busy is high during reset, no clearing pass.
module text_terminal_line_buffer_unit
   import ttlb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int SUM_W  = (SLOT_W > 9 ? SLOT_W : 9) + 2;
   localparam int LCMP_W = (TOTAL_W > 9 ? TOTAL_W : 9) + 1;
   localparam int CCMP_W = (LEN_W > 7 ? LEN_W : 7) + 1;

   cmd_out_type cmd_out;
   logic accept;

   logic [SLOT_W-1:0]  slot_ff, slot_in, slot_next;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               busy_ff, rsp_valid_ff;
   logic               fetch_ff, line_ok_ff, newest_sel_ff;
   logic [6:0]         col_ff;

   logic               len_we, char_we, is_fetch;
   logic [CHAR_AW-1:0] char_waddr, char_raddr;
   logic [SUM_W-1:0]   sum;
   logic [SLOT_W-1:0]  fetch_slot;
   logic [LEN_W-1:0]   len_rdata, len_sel;
   logic [15:0]        char_rdata, wv;
   logic               fetch_hit;

   assign accept   = start && !busy;
   assign is_fetch = accept && (req_item.req_type == REQ_FETCH);
   assign wv       = req_item.write_value;

   ttlb_cmd u_cmd (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .req_type    (req_item.req_type),
      .write_value (wv),
      .cmd_out     (cmd_out)
   );

   // Lengths of the older lines; the newest length lives in len_ff
   ttlb_ram #(.DEPTH(LINE_CAPACITY), .WIDTH(LEN_W)) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (slot_ff),
      .wdata (len_ff),
      .re    (is_fetch),
      .raddr (fetch_slot),
      .rdata (len_rdata)
   );

   ttlb_ram #(.DEPTH(CHAR_DEPTH), .WIDTH(16)) u_char_ram (
      .clock (clock),
      .we    (char_we),
      .waddr (char_waddr),
      .wdata (wv),
      .re    (is_fetch),
      .raddr (char_raddr),
      .rdata (char_rdata)
   );

   // Map fetch line to ring slot, counting back from the newest
   always_comb begin
      sum = SUM_W'(slot_ff) + SUM_W'(LINE_CAPACITY) - SUM_W'(req_item.fetch_line);
      if (sum >= SUM_W'(LINE_CAPACITY)) begin
         sum = sum - SUM_W'(LINE_CAPACITY);
      end
      fetch_slot = SLOT_W'(sum);
   end

   assign char_raddr = CHAR_AW'(CHAR_AW'(fetch_slot) * CHAR_AW'(LINE_WIDTH) +
                                CHAR_AW'(req_item.fetch_column));
   assign char_waddr = CHAR_AW'(CHAR_AW'(slot_ff) * CHAR_AW'(LINE_WIDTH) +
                                CHAR_AW'(len_ff));
   assign slot_next  = (slot_ff == SLOT_W'(LINE_CAPACITY - 1)) ? '0 :
                       SLOT_W'(slot_ff + 1'b1);

   // Edit the newest line; line feed starts a new one, form feed clears the line count
   always_comb begin
      slot_in  = slot_ff;
      total_in = total_ff;
      len_in   = len_ff;
      len_we   = 1'b0;
      char_we  = 1'b0;
      if (cmd_out.edit_en) begin
         priority if (wv == CH_BS || wv == CH_DEL || wv == CH_CCH) begin
            if (len_ff != '0) begin
               len_in = LEN_W'(len_ff - 1'b1);
            end
         end else if (wv == CH_LF) begin
            len_we  = 1'b1;
            slot_in = slot_next;
            len_in  = '0;
            if (total_ff < TOTAL_W'(LINE_CAPACITY)) begin
               total_in = TOTAL_W'(total_ff + 1'b1);
            end
         end else if (wv == CH_FF) begin
            total_in = TOTAL_W'(1);
            len_in   = '0;
         end else if (wv == CH_CR) begin
            len_in = '0;
         end else if (!(wv < CH_SPACE || (wv >= CH_DEL && wv < CH_NBSP))) begin
            if (len_ff < LEN_W'(LINE_WIDTH)) begin
               char_we = 1'b1;
               len_in  = LEN_W'(len_ff + 1'b1);
            end
         end else begin
            len_in = len_ff;
         end
      end
   end

   // Hold ring state and the fetch lookup of the last item
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         total_ff     <= TOTAL_W'(1);
         len_ff       <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         fetch_ff     <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         total_ff     <= total_in;
         len_ff       <= len_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            fetch_ff <= is_fetch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_fetch) begin
         line_ok_ff    <= LCMP_W'(req_item.fetch_line) < LCMP_W'(total_ff);
         newest_sel_ff <= (req_item.fetch_line == 9'd0);
         col_ff        <= req_item.fetch_column;
      end
   end

   // Form the result from the registered lookups
   assign len_sel   = newest_sel_ff ? len_ff : len_rdata;
   assign fetch_hit = fetch_ff && line_ok_ff && (CCMP_W'(col_ff) < CCMP_W'(len_sel));

   always_comb begin
      rsp_item.read_data     = cmd_out.read_data;
      rsp_item.fetch_char    = fetch_hit ? char_rdata : 16'd0;
      rsp_item.fetch_valid   = fetch_hit;
      rsp_item.lines_held    = 10'(total_ff);
      rsp_item.newest_length = 8'(len_ff);
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/ttlb_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// Depends on nothing.
module ttlb_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, registered and gated by re
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/ttlb_cmd.sv @@
// Command state machine and configuration registers of the line buffer.
// Depends on ttlb_pkg.
module ttlb_cmd
   import ttlb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         accept,
   input  logic [1:0]   req_type,
   input  logic [15:0]  write_value,
   output cmd_out_type  cmd_out
);

   logic [15:0] code_hard_ff, code_chars_ff, code_term_ff, code_cmd_ff;
   logic [15:0] columns_ff, rows_ff;
   write_mode_type wmode_ff, wmode_in;
   read_mode_type  rmode_ff, rmode_in;
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] rd_ff, rd_in;
   logic        is_write, is_read;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_hard_ff  <= 16'd1;
         code_chars_ff <= 16'd2;
         code_term_ff  <= 16'd3;
         code_cmd_ff   <= 16'd4;
         columns_ff    <= 16'd80;
         rows_ff       <= 16'd24;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CODE_HARDWARE: code_hard_ff  <= csr_wdata;
            CSR_CODE_CHARS:    code_chars_ff <= csr_wdata;
            CSR_CODE_TERM:     code_term_ff  <= csr_wdata;
            CSR_CODE_COMMAND:  code_cmd_ff   <= csr_wdata;
            CSR_TERM_COLUMNS:  columns_ff    <= csr_wdata;
            CSR_TERM_ROWS:     rows_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign is_write = accept && (req_type == REQ_WRITE);
   assign is_read  = accept && (req_type == REQ_READ);

   // Decode written words and advance the size readout
   always_comb begin
      wmode_in = wmode_ff;
      rmode_in = rmode_ff;
      pos_in   = pos_ff;
      rd_in    = 16'd0;
      if (is_write) begin
         unique case (wmode_ff)
            WM_CHARS: begin
               if (write_value == CH_NUL) begin
                  wmode_in = WM_IDLE;
               end
            end
            WM_COMMAND: begin
               wmode_in = WM_IDLE;
            end
            default: begin
               priority if (write_value == code_hard_ff) begin
                  rmode_in = RM_HARD;
               end else if (write_value == code_chars_ff) begin
                  wmode_in = WM_CHARS;
                  rmode_in = RM_NONE;
               end else if (write_value == code_term_ff) begin
                  rmode_in = RM_TERM;
                  pos_in   = 2'd0;
               end else if (write_value == code_cmd_ff) begin
                  wmode_in = WM_COMMAND;
                  rmode_in = RM_NONE;
               end else begin
                  wmode_in = wmode_ff;
               end
            end
         endcase
      end else if (is_read && (rmode_ff == RM_TERM)) begin
         priority if (pos_ff == 2'd0) begin
            rd_in  = columns_ff;
            pos_in = 2'd1;
         end else if (pos_ff == 2'd1) begin
            rd_in  = rows_ff;
            pos_in = 2'd2;
         end else begin
            rd_in = 16'd0;
         end
      end
   end

   // Hold mode state and the read word of the last item
   always_ff @(posedge clock) begin
      if (reset) begin
         wmode_ff <= WM_IDLE;
         rmode_ff <= RM_NONE;
         pos_ff   <= 2'd0;
         rd_ff    <= 16'd0;
      end else begin
         wmode_ff <= wmode_in;
         rmode_ff <= rmode_in;
         pos_ff   <= pos_in;
         if (accept) begin
            rd_ff <= rd_in;
         end
      end
   end

   assign cmd_out.edit_en   = is_write && (wmode_ff == WM_CHARS) &&
                              (write_value != CH_NUL);
   assign cmd_out.read_data = rd_ff;

endmodule

@@ tb/tb_text_terminal_line_buffer_unit.sv @@
// Self-checking testbench for text_terminal_line_buffer_unit: command decode, line ring edits,
// size readout and scanout fetch, checked against a scoreboard that predicts every result.
// Depends on ttlb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_text_terminal_line_buffer_unit;
   import ttlb_pkg::*;

   // No-op request code; the package names only the three real request types
   localparam logic [1:0] REQ_NOP = 2'd3;

   // Scoreboard: shadow copy of the terminal state and the queue of predicted results
   class line_ring_scoreboard;
      logic [15:0]    csr_regs [6];
      write_mode_type wmode;
      read_mode_type  rmode;
      int             size_pos;
      int             newest_slot;
      int             line_total;
      int             line_len [LINE_CAPACITY];
      logic [15:0]    char_mem [CHAR_DEPTH];
      rsp_item_type   pending_results [$];
      int             fault_count;

      function new();
         csr_regs[CSR_CODE_HARDWARE] = 16'd1;
         csr_regs[CSR_CODE_CHARS]    = 16'd2;
         csr_regs[CSR_CODE_TERM]     = 16'd3;
         csr_regs[CSR_CODE_COMMAND]  = 16'd4;
         csr_regs[CSR_TERM_COLUMNS]  = 16'd80;
         csr_regs[CSR_TERM_ROWS]     = 16'd24;
         wmode       = WM_IDLE;
         rmode       = RM_NONE;
         size_pos    = 0;
         newest_slot = 0;
         line_total  = 1;
         fault_count = 0;
         foreach (line_len[i]) line_len[i] = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [15:0] value);
         csr_regs[idx] = value;
      endfunction

      // Ring slot of the line that is age lines older than the newest
      function int slot_of(int age);
         return (newest_slot + LINE_CAPACITY - age) % LINE_CAPACITY;
      endfunction

      function int length_at(int age);
         return (age < line_total) ? line_len[slot_of(age)] : 0;
      endfunction

      // Apply one character-mode word to the ring
      function void edit_line(logic [15:0] c);
         int len;
         len = line_len[newest_slot];
         case (c)
            CH_NUL: wmode = WM_IDLE;
            CH_BS, CH_DEL, CH_CCH: if (len > 0) line_len[newest_slot] = len - 1;
            CH_LF: begin
               newest_slot = (newest_slot + 1) % LINE_CAPACITY;
               line_len[newest_slot] = 0;
               if (line_total < LINE_CAPACITY) line_total++;
            end
            CH_FF: begin
               line_total = 1;
               line_len[newest_slot] = 0;
            end
            CH_CR: line_len[newest_slot] = 0;
            default: begin
               // Drop control and C1 codes, and anything past a full line
               if (!(c < CH_SPACE || (c >= CH_DEL && c < CH_NBSP)) && len < LINE_WIDTH) begin
                  char_mem[newest_slot * LINE_WIDTH + len] = c;
                  line_len[newest_slot] = len + 1;
               end
            end
         endcase
      endfunction

      // Command state machine for a written word; first matching code wins
      function void take_word(logic [15:0] w);
         if (wmode == WM_CHARS) begin
            edit_line(w);
         end else if (wmode == WM_COMMAND) begin
            wmode = WM_IDLE;
         end else if (w == csr_regs[CSR_CODE_HARDWARE]) begin
            rmode = RM_HARD;
         end else if (w == csr_regs[CSR_CODE_CHARS]) begin
            wmode = WM_CHARS;
            rmode = RM_NONE;
         end else if (w == csr_regs[CSR_CODE_TERM]) begin
            rmode    = RM_TERM;
            size_pos = 0;
         end else if (w == csr_regs[CSR_CODE_COMMAND]) begin
            wmode = WM_COMMAND;
            rmode = RM_NONE;
         end
      endfunction

      // Columns, then rows, then zero; zero outside size readout
      function logic [15:0] next_size_word();
         if (rmode != RM_TERM) return 16'd0;
         if (size_pos == 0) begin
            size_pos = 1;
            return csr_regs[CSR_TERM_COLUMNS];
         end
         if (size_pos == 1) begin
            size_pos = 2;
            return csr_regs[CSR_TERM_ROWS];
         end
         return 16'd0;
      endfunction

      // Advance the shadow state by one accepted item and queue its result
      function void note_request(req_item_type it);
         rsp_item_type r;
         int           slot;
         r = '0;
         case (it.req_type)
            REQ_WRITE: take_word(it.write_value);
            REQ_READ:  r.read_data = next_size_word();
            REQ_FETCH: begin
               if (int'(it.fetch_line) < line_total) begin
                  slot = slot_of(int'(it.fetch_line));
                  if (int'(it.fetch_column) < line_len[slot]) begin
                     r.fetch_char  = char_mem[slot * LINE_WIDTH + int'(it.fetch_column)];
                     r.fetch_valid = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         r.lines_held    = 10'(line_total);
         r.newest_length = 8'(line_len[newest_slot]);
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void log_fault(string msg);
         fault_count++;
         if (fault_count <= 10) $display("%t %s", $realtime, msg);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want)
            log_fault($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
      endfunction

      // Compare one strobed result with the oldest prediction
      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            log_fault("result strobed with no item pending");
            return;
         end
         want = pending_results.pop_front();
         check_field("read_data", want.read_data, got.read_data);
         check_field("fetch_char", want.fetch_char, got.fetch_char);
         check_field("fetch_valid", 16'(want.fetch_valid), 16'(got.fetch_valid));
         check_field("lines_held", 16'(want.lines_held), 16'(got.lines_held));
         check_field("newest_length", 16'(want.newest_length), 16'(got.newest_length));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [15:0]  csr_wdata;

   line_ring_scoreboard sb;
   int items_sent = 0;
   int gap_odds   = 4;
   bit quiet_tail = 0;

   text_terminal_line_buffer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("tb_text_terminal_line_buffer_unit: errors");
      $finish;
   end

   // Check every strobed result; the receiver cannot hold results off
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_response(rsp_item);
   end

   function automatic req_item_type make_item(logic [1:0] kind, logic [15:0] word,
                                              logic [8:0] line, logic [6:0] col);
      req_item_type it;
      it.req_type     = kind;
      it.write_value  = word;
      it.fetch_line   = line;
      it.fetch_column = col;
      return it;
   endfunction

   // Drive one item, optionally after a gap, and hold until it is accepted
   task automatic send(input req_item_type it);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_item <= it;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_request(it);
      items_sent++;
   endtask

   task automatic put_word(input logic [15:0] w);
      send(make_item(REQ_WRITE, w, 9'($urandom), 7'($urandom)));
   endtask

   task automatic get_word();
      send(make_item(REQ_READ, 16'($urandom), 9'($urandom), 7'($urandom)));
   endtask

   task automatic fetch_at(input logic [8:0] line, input logic [6:0] col);
      send(make_item(REQ_FETCH, 16'($urandom), line, col));
   endtask

   // Fetch mostly inside the held text, sometimes anywhere
   task automatic fetch_random();
      int age;
      int col;
      if ($urandom_range(0, 3) == 0) begin
         age = $urandom_range(0, 511);
      end else begin
         age = $urandom_range(0, sb.line_total);
         if (age > 511) age = 511;
      end
      if ($urandom_range(0, 3) == 0) begin
         col = $urandom_range(0, 127);
      end else begin
         col = $urandom_range(0, sb.length_at(age));
         if (col > 127) col = 127;
      end
      fetch_at(9'(age), 7'(col));
   endtask

   // Hold the sender until every predicted result has arrived
   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   // Reprogram every register while the block is idle
   task automatic write_settings(input logic [15:0] hw, chars, term, cmd, cols, rows);
      drain();
      @(posedge clock);
      csr_put(CSR_CODE_HARDWARE, hw);
      csr_put(CSR_CODE_CHARS, chars);
      csr_put(CSR_CODE_TERM, term);
      csr_put(CSR_CODE_COMMAND, cmd);
      csr_put(CSR_TERM_COLUMNS, cols);
      csr_put(CSR_TERM_ROWS, rows);
      csr_we <= 1'b0;
   endtask

   // Character word weighted toward the codes that edit the ring
   function automatic logic [15:0] pick_char_word();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 16'($urandom_range(16'h20, 16'h7E));
      if (p < 50) return 16'($urandom_range(16'hA0, 16'hFFFF));
      if (p < 58) return CH_LF;
      if (p < 62) return CH_BS;
      if (p < 65) return CH_DEL;
      if (p < 67) return CH_CCH;
      if (p < 69) return CH_FF;
      if (p < 73) return CH_CR;
      if (p < 79) return 16'($urandom_range(1, 31));
      if (p < 85) return 16'($urandom_range(16'h80, 16'h9F));
      if (p < 87) return CH_NUL;
      return 16'($urandom);
   endfunction

   // Get the command machine into character mode from wherever it is
   task automatic enter_char_mode();
      if (sb.wmode == WM_COMMAND) put_word(16'($urandom));
      if (sb.wmode != WM_CHARS) put_word(sb.csr_regs[CSR_CODE_CHARS]);
   endtask

   task automatic run_directed();
      get_word();
      fetch_at(9'd0, 7'd0);
      send(make_item(REQ_NOP, 16'hFFFF, 9'h1FF, 7'h7F));
      // size readout runs out after two words
      put_word(sb.csr_regs[CSR_CODE_TERM]);
      get_word();
      get_word();
      get_word();
      // hardware mode reads zero
      put_word(sb.csr_regs[CSR_CODE_HARDWARE]);
      get_word();
      // command mode swallows the next word, even a command code
      put_word(sb.csr_regs[CSR_CODE_COMMAND]);
      put_word(sb.csr_regs[CSR_CODE_CHARS]);
      get_word();
      // character mode edits
      put_word(sb.csr_regs[CSR_CODE_CHARS]);
      put_word(CH_BS);
      put_word(16'h0041);
      put_word(16'hFFFF);
      put_word(CH_SPACE);
      put_word(16'h009F);
      put_word(CH_NBSP);
      put_word(CH_CCH);
      put_word(CH_DEL);
      put_word(CH_CR);
      put_word(16'h0042);
      put_word(CH_LF);
      put_word(16'h0043);
      fetch_at(9'd1, 7'd0);
      fetch_at(9'd0, 7'd0);
      fetch_at(9'd0, 7'd1);
      fetch_at(9'd2, 7'd0);
      put_word(CH_FF);
      fetch_at(9'd1, 7'd0);
      put_word(CH_NUL);
   endtask

   // Fill one line to near or past its width and probe its last columns
   task automatic long_line();
      int n;
      enter_char_mode();
      put_word(CH_CR);
      n = $urandom_range(LINE_WIDTH - 3, LINE_WIDTH + 5);
      repeat (n) put_word(16'($urandom_range(16'h21, 16'hFFFF) | 16'h0100));
      fetch_at(9'd0, 7'd127);
      fetch_at(9'd0, 7'd126);
      fetch_at(9'd0, 7'($urandom));
      put_word(CH_BS);
      put_word(CH_LF);
   endtask

   // Push the ring to capacity so the oldest lines are dropped
   task automatic fill_ring();
      enter_char_mode();
      repeat (LINE_CAPACITY + 2) begin
         if ($urandom_range(0, 15) == 0) put_word(16'($urandom_range(16'h21, 16'h7E)));
         put_word(CH_LF);
      end
      fetch_at(9'd511, 7'd0);
      fetch_at(9'd510, 7'($urandom_range(0, 2)));
      repeat (8) fetch_random();
   endtask

   task automatic run_random(input int count);
      int stop;
      int p;
      int k;
      stop = items_sent + count;
      while (items_sent < stop) begin
         // vary the sender's idling; keep it off in the tail
         if (quiet_tail) begin
            gap_odds = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: gap_odds = 0;
               1: gap_odds = 4;
               default: gap_odds = 12;
            endcase
         end
         if (!quiet_tail && $urandom_range(0, 49) == 0) drain();
         p = $urandom_range(0, 99);
         if (p < 45) begin
            enter_char_mode();
            repeat ($urandom_range(1, 30)) begin
               k = $urandom_range(0, 99);
               if (k < 60) put_word(pick_char_word());
               else if (k < 85) fetch_random();
               else if (k < 95) get_word();
               else send(make_item(REQ_NOP, 16'($urandom), 9'($urandom), 7'($urandom)));
            end
            if ($urandom_range(0, 1) == 0) put_word(CH_NUL);
         end else if (p < 60) begin
            put_word(sb.csr_regs[CSR_CODE_TERM]);
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 5) == 0) put_word(16'($urandom));
               get_word();
            end
         end else if (p < 68) begin
            put_word(sb.csr_regs[CSR_CODE_HARDWARE]);
            repeat ($urandom_range(1, 3)) get_word();
         end else if (p < 76) begin
            put_word(sb.csr_regs[CSR_CODE_COMMAND]);
            if ($urandom_range(0, 1) == 0) put_word(sb.csr_regs[CSR_CODE_CHARS]);
            else put_word(16'($urandom));
            get_word();
         end else if (p < 93) begin
            send(make_item(2'($urandom), 16'($urandom), 9'($urandom), 7'($urandom)));
         end else begin
            long_line();
         end
      end
   endtask

   initial begin : stimulus
      sb = new();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers first
      run_directed();

      // Extreme codes and size words
      write_settings(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
      run_random(8);

      // All codes equal: hardware wins
      write_settings(16'd5, 16'd5, 16'd5, 16'd5, 16'h0001, 16'hFFFF);
      run_random(6);

      // Character mode wins over size readout and command mode
      write_settings(16'h0010, 16'd6, 16'd6, 16'd6, 16'd80, 16'd24);
      run_random(8);

      // Size readout wins over command mode
      write_settings(16'd9, 16'd8, 16'd7, 16'd7, 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 65535)));
      run_random(8);

      // Ring at capacity
      write_settings(16'd1, 16'd2, 16'd3, 16'd4, 16'd80, 16'd24);
      fill_ring();
      run_random(6);

      write_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      run_random(16);

      // Back-to-back tail with no idling
      write_settings(16'h00A0, 16'h0041, 16'h0000, 16'hFFFE, 16'd132, 16'd43);
      quiet_tail = 1;
      gap_odds   = 0;
      run_random(24);

      drain();
      if (sb.pending_results.size() != 0)
         sb.log_fault($sformatf("%0d results never arrived", sb.pending_results.size()));
      repeat (4) @(posedge clock);
      if (sb.fault_count == 0) begin
         $display("tb_text_terminal_line_buffer_unit: clean");
      end else begin
         $display("tb_text_terminal_line_buffer_unit: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/ttlb_pkg.sv
design/ttlb_ram.sv
design/ttlb_cmd.sv
design/text_terminal_line_buffer_unit.sv
tb/tb_text_terminal_line_buffer_unit.sv
